>>> rtl/rlb_pkg.sv
// Shared constants, command types and field widths for the run-length line buffer loader.
`default_nettype none

package rlb_pkg;

  // Line store geometry
  localparam int BUF_BYTES = 4096;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int CAP_BITS  = BUF_BYTES * 8;
  localparam int PTR_W     = $clog2(CAP_BITS + 1);

  // Field and counter widths
  localparam int MODE_W  = 2;
  localparam int DATA_W  = 8;
  localparam int RIDX_W  = 12;
  localparam int STAT_W  = 2;
  localparam int FILL_W  = 16;
  localparam int CFG_W   = 13;
  localparam int LEN_W   = 16;
  localparam int CNT_W   = 17;
  localparam int RUN_W   = 15;
  localparam int QUEUE_DEPTH = 4;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_RAW  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COMP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_PENDING  = 2'd0;
  localparam logic [STAT_W-1:0] ST_DONE     = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

  // Token fields
  localparam logic [DATA_W-1:0] TOKEN_ONES_BIT = 8'h80;
  localparam logic [DATA_W-1:0] TOKEN_LEN_MASK = 8'h7f;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_RAW,
    CMD_RUN,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic                finish;
    logic                mismatch;
    logic                in_range;
    logic                ones;
    logic [DATA_W-1:0]   data;
    logic [ADDR_W-1:0]   addr;
    logic [RUN_W-1:0]    run_len;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/rlb_front.sv
// Front end: frame parser that turns each beat into one command for the back end.
`default_nettype none

module rlb_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wen,
  input  wire logic [rlb_pkg::CFG_W-1:0]   cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rlb_pkg::MODE_W-1:0]  mode,
  input  wire logic [rlb_pkg::DATA_W-1:0]  data_byte,
  input  wire logic [rlb_pkg::RIDX_W-1:0]  read_index,
  input  wire logic                        queue_full,
  output logic                             cmd_push,
  output rlb_pkg::cmd_t                    cmd
);
  import rlb_pkg::*;

  typedef enum logic [1:0] {
    PH_LEN_HI,
    PH_LEN_LO,
    PH_RAW,
    PH_COMP
  } phase_t;

  phase_t            phase, phase_next;
  logic [CFG_W-1:0]  line_bytes;
  logic [LEN_W-1:0]  frame_length, frame_length_next;
  logic [CNT_W-1:0]  byte_count, byte_count_next;
  logic [DATA_W-1:0] token_high, token_high_next;
  logic [CNT_W-1:0]  count_inc;
  logic [LEN_W-1:0]  len_full;
  logic              accept;

  assign in_ready  = !queue_full;
  assign accept    = in_valid && in_ready;
  assign cmd_push  = accept;
  assign count_inc = byte_count + CNT_W'(1);
  assign len_full  = {frame_length[LEN_W-1:DATA_W], data_byte};

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    byte_count_next   = byte_count;
    token_high_next   = token_high;
    cmd               = '0;
    cmd.kind          = CMD_NONE;
    if (mode == MODE_READ) begin
      cmd.kind     = CMD_READ;
      cmd.addr     = ADDR_W'(read_index);
      cmd.in_range = 32'(read_index) < BUF_BYTES;
    end else if (mode == MODE_RAW || mode == MODE_COMP) begin
      case (phase)
        PH_LEN_HI: begin
          frame_length_next = {data_byte, 8'h00};
          phase_next        = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          frame_length_next = len_full;
          byte_count_next   = '0;
          token_high_next   = '0;
          cmd.kind          = CMD_START;
          if (mode == MODE_RAW) begin
            if (len_full != LEN_W'(line_bytes)) begin
              cmd.mismatch = 1'b1;
              phase_next   = PH_LEN_HI;
            end else if (len_full == '0) begin
              cmd.finish = 1'b1;
              phase_next = PH_LEN_HI;
            end else begin
              phase_next = PH_RAW;
            end
          end else begin
            if (len_full == '0) begin
              cmd.finish = 1'b1;
              phase_next = PH_LEN_HI;
            end else begin
              phase_next = PH_COMP;
            end
          end
        end
        PH_RAW: begin
          cmd.kind        = CMD_RAW;
          cmd.data        = data_byte;
          cmd.addr        = ADDR_W'(byte_count);
          cmd.in_range    = byte_count < CNT_W'(BUF_BYTES);
          byte_count_next = count_inc;
          cmd.finish      = count_inc >= CNT_W'(frame_length);
          if (cmd.finish) begin
            phase_next = PH_LEN_HI;
          end
        end
        PH_COMP: begin
          byte_count_next = count_inc;
          if (count_inc[0]) begin
            token_high_next = data_byte;
          end else begin
            cmd.kind    = CMD_RUN;
            cmd.ones    = (token_high & TOKEN_ONES_BIT) != '0;
            cmd.run_len = {7'(token_high & TOKEN_LEN_MASK), data_byte};
            cmd.finish  = count_inc >= CNT_W'(frame_length);
            if (cmd.finish) begin
              phase_next = PH_LEN_HI;
            end
          end
        end
        default: begin
          phase_next = PH_LEN_HI;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEN_HI;
      line_bytes   <= '0;
      frame_length <= '0;
      byte_count   <= '0;
      token_high   <= '0;
    end else begin
      if (cfg_wen) begin
        line_bytes <= cfg_wdata;
      end
      if (accept) begin
        phase        <= phase_next;
        frame_length <= frame_length_next;
        byte_count   <= byte_count_next;
        token_high   <= token_high_next;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/rlb_queue.sv
// Short command queue between the frame parser and the line store writer.
`default_nettype none

module rlb_queue (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  rlb_pkg::cmd_t push_cmd,
  input  wire logic     pop,
  output rlb_pkg::cmd_t head_cmd,
  output logic          full,
  output logic          empty
);
  import rlb_pkg::*;

  localparam int QP_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [QP_W-1:0]  wr_ptr;
  logic [QP_W-1:0]  rd_ptr;
  logic [QC_W-1:0]  count;

  assign full     = count == QC_W'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign head_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QP_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QP_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QC_W'(1);
        2'b01:   count <= count - QC_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/rlb_back.sv
// Back end: line store, bit pointer, run writer and result register.
`default_nettype none

module rlb_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  rlb_pkg::cmd_t                    head_cmd,
  input  wire logic                        queue_empty,
  output logic                             pop,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output logic [rlb_pkg::STAT_W-1:0]       status,
  output logic [rlb_pkg::DATA_W-1:0]       read_data,
  output logic [rlb_pkg::FILL_W-1:0]       fill_bits
);
  import rlb_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_RUN,
    B_MERGE
  } bstate_t;

  bstate_t           state;
  logic [PTR_W-1:0]  ptr;
  logic              ovf;
  logic [RUN_W-1:0]  rem;
  logic              ones;
  logic              finish;
  logic              read_ok;

  logic [DATA_W-1:0] store [BUF_BYTES];
  logic [DATA_W-1:0] mem_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  logic [2:0]        off;
  logic [3:0]        room;
  logic [3:0]        n_bits;
  logic              full_byte;
  logic              at_cap;
  logic [ADDR_W-1:0] byte_addr;
  logic [DATA_W-1:0] mask;
  logic [PTR_W-1:0]  raw_ptr;

  function automatic logic [STAT_W-1:0] end_status(input logic fin, input logic ov);
    if (!fin) begin
      return ST_PENDING;
    end
    return ov ? ST_OVERFLOW : ST_DONE;
  endfunction

  assign off       = ptr[2:0];
  assign room      = 4'd8 - {1'b0, off};
  assign n_bits    = (rem < RUN_W'(room)) ? rem[3:0] : room;
  assign full_byte = (off == 3'd0) && (rem >= RUN_W'(8));
  assign at_cap    = ptr >= PTR_W'(CAP_BITS);
  assign byte_addr = ADDR_W'(ptr >> 3);
  assign mask      = (8'hff >> off) & ~(8'hff >> ({1'b0, off} + n_bits));
  assign raw_ptr   = PTR_W'({(PTR_W - 3)'(head_cmd.addr) + (PTR_W - 3)'(1), 3'b000});

  assign pop       = (state == B_IDLE) && !queue_empty && !res_valid;
  assign mem_raddr = (state == B_IDLE) ? head_cmd.addr : byte_addr;
  assign fill_bits = (32'(ptr) > 32'hffff) ? FILL_W'(16'hffff) : FILL_W'(ptr);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = byte_addr;
    mem_wdata = ones ? 8'hff : 8'h00;
    case (state)
      B_IDLE: begin
        if (pop && head_cmd.kind == CMD_RAW && head_cmd.in_range) begin
          mem_we    = 1'b1;
          mem_waddr = head_cmd.addr;
          mem_wdata = head_cmd.data;
        end
      end
      B_RUN: begin
        mem_we = (rem != '0) && !at_cap && full_byte;
      end
      B_MERGE: begin
        mem_we    = 1'b1;
        mem_wdata = ones ? (mem_q | mask) : (mem_q & ~mask);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    mem_q <= store[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      ptr       <= '0;
      ovf       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop) begin
            case (head_cmd.kind)
              CMD_START: begin
                ptr       <= '0;
                ovf       <= 1'b0;
                status    <= head_cmd.mismatch ? ST_MISMATCH
                                               : end_status(head_cmd.finish, 1'b0);
                read_data <= '0;
                res_valid <= 1'b1;
              end
              CMD_RAW: begin
                if (head_cmd.in_range) begin
                  ptr <= raw_ptr;
                end else begin
                  ovf <= 1'b1;
                end
                status    <= end_status(head_cmd.finish, ovf || !head_cmd.in_range);
                read_data <= '0;
                res_valid <= 1'b1;
              end
              CMD_RUN: begin
                rem    <= head_cmd.run_len;
                ones   <= head_cmd.ones;
                finish <= head_cmd.finish;
                state  <= B_RUN;
              end
              CMD_READ: begin
                read_ok <= head_cmd.in_range;
                state   <= B_READ;
              end
              default: begin
                status    <= ST_PENDING;
                read_data <= '0;
                res_valid <= 1'b1;
              end
            endcase
          end
        end
        B_READ: begin
          status    <= ST_PENDING;
          read_data <= read_ok ? mem_q : '0;
          res_valid <= 1'b1;
          state     <= B_IDLE;
        end
        B_RUN: begin
          if (rem == '0) begin
            status    <= end_status(finish, ovf);
            read_data <= '0;
            res_valid <= 1'b1;
            state     <= B_IDLE;
          end else if (at_cap) begin
            // drop the rest of the run
            ovf       <= 1'b1;
            status    <= end_status(finish, 1'b1);
            read_data <= '0;
            res_valid <= 1'b1;
            state     <= B_IDLE;
          end else if (full_byte) begin
            ptr <= ptr + PTR_W'(8);
            rem <= rem - RUN_W'(8);
          end else begin
            state <= B_MERGE;
          end
        end
        B_MERGE: begin
          ptr   <= ptr + PTR_W'(n_bits);
          rem   <= rem - RUN_W'(n_bits);
          state <= B_RUN;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/run_length_line_buffer_loader.sv
// Top level of the run-length line buffer loader: stream ports, parser, queue and writer.
// Each accepted beat is queued as a command; the writer pops it and registers its result, a read after a store read.
// A run writes whole bytes straight to the line store and merges a partial byte by reading it back first,
// all through the single write port of the line store.
// A four-entry command queue takes beats while the writer is busy or a result waits.
// Synchronous reset clears parser, queue, pointer and result flags; the store is not cleared.
`default_nettype none

module run_length_line_buffer_loader (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [12:0] cfg_wdata,   // line_bytes
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,     // [7:0] data_byte, [19:8] read_index, [23:20] zero
  input  wire logic [1:0]  s_tuser,     // [1:0] mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata      // [1:0] status, [9:2] read_data, [25:10] fill_bits
);
  import rlb_pkg::*;

  cmd_t              push_cmd;
  cmd_t              head_cmd;
  logic              cmd_push;
  logic              cmd_pop;
  logic              queue_full;
  logic              queue_empty;
  logic [STAT_W-1:0] status;
  logic [DATA_W-1:0] read_data;
  logic [FILL_W-1:0] fill_bits;

  // Parse the frame header and tokens; one command per accepted beat
  rlb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .mode       (s_tuser),
    .data_byte  (s_tdata[7:0]),
    .read_index (s_tdata[19:8]),
    .queue_full (queue_full),
    .cmd_push   (cmd_push),
    .cmd        (push_cmd)
  );

  // Hold commands so the parser keeps taking beats during long runs
  rlb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .pop      (cmd_pop),
    .head_cmd (head_cmd),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  // Carry out writes, runs and reads against the line store; one result per command
  rlb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_cmd    (head_cmd),
    .queue_empty (queue_empty),
    .pop         (cmd_pop),
    .res_valid   (m_tvalid),
    .res_ready   (m_tready),
    .status      (status),
    .read_data   (read_data),
    .fill_bits   (fill_bits)
  );

  assign m_tdata = {6'b000000, fill_bits, read_data, status};

endmodule

`default_nettype wire

>>> tb/tb_run_length_line_buffer_loader.sv
// Self-checking testbench for the run-length line buffer loader: stream stimulus and result check.
`timescale 1ns / 1ps

module tb_run_length_line_buffer_loader;
  import rlb_pkg::*;

  // Mode 3 has no name in the package; the block ignores it
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

  localparam int IDLE_PCT      = 28;     // idle cycles per hundred on either side
  localparam int HOLD_CYCLES   = 80;     // long receiver hold-off, fills the command queue
  localparam int SETTLE_CYCLES = 8;      // margin beyond the result latency
  localparam int RANDOM_BEATS  = 48;
  localparam int STREAM_BYTES  = 32;     // raw line streamed with no idling
  // Slowest run: every one of the ~140 beats completing a full-capacity run
  // while both sides idle and the receiver is held off; taken several times over.
  localparam int CYCLE_LIMIT   = 2000000;

  typedef enum logic [1:0] {AWAIT_HI, AWAIT_LO, RAW_BYTES, RUN_TOKENS} loader_phase_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] read_data;
    logic [FILL_W-1:0] fill_bits;
  } line_result_t;

  // ---------------------------------------------------------------------------------------
  // Block under test
  // ---------------------------------------------------------------------------------------
  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_wen   = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata   = '0;   // [7:0] data_byte, [19:8] read_index, [23:20] zero
  logic [MODE_W-1:0] s_tuser   = '0;   // [1:0] mode
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [31:0]       m_tdata;          // [1:0] status, [9:2] read_data, [25:10] fill_bits

  run_length_line_buffer_loader dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Shadow of the loader: parser state, line length register and a copy of the line store.
  // line_known marks which bits of each byte have been written; a byte is read back only
  // once all eight are known, since the store comes out of reset undefined.
  // ---------------------------------------------------------------------------------------
  logic [CFG_W-1:0] line_bytes_cfg = '0;
  loader_phase_t    ld_phase       = AWAIT_HI;
  logic [LEN_W-1:0] ld_frame_len   = '0;
  int               ld_byte_cnt    = 0;
  logic [7:0]       ld_token_hi    = '0;
  int               ld_bit_ptr     = 0;
  logic             ld_overflow    = 1'b0;
  bit   [7:0]       line_copy  [BUF_BYTES];
  bit   [7:0]       line_known [BUF_BYTES];
  int               readable[$];

  line_result_t     pending_results[$];

  // Run bookkeeping
  int  cycle_count    = 0;
  int  mismatch_count = 0;
  int  results_seen   = 0;
  int  beats_sent     = 0;
  int  frames_ok      = 0;
  int  frames_refused = 0;
  int  frames_clipped = 0;
  int  reads_done     = 0;
  int  settings_used  = 0;
  logic no_idle       = 1'b0;

  // Receiver hold-off: toggling hold_go starts a count of HOLD_CYCLES
  logic hold_go   = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  // ---------------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------------
  function automatic void note_known(int idx, logic [7:0] mask);
    if (line_known[idx] != 8'hFF && (line_known[idx] | mask) == 8'hFF)
      readable.push_back(idx);
    line_known[idx] |= mask;
  endfunction

  // Append a run MSB-first; stop and flag once the line is full
  function automatic void lay_run(logic ones, int count);
    int         idx;
    logic [7:0] m;
    for (int k = 0; k < count; k++) begin
      if (ld_bit_ptr >= CAP_BITS) begin
        ld_overflow = 1'b1;
        return;
      end
      idx = ld_bit_ptr / 8;
      m   = 8'h80 >> (ld_bit_ptr % 8);
      line_copy[idx] = ones ? (line_copy[idx] | m) : (line_copy[idx] & ~m);
      note_known(idx, m);
      ld_bit_ptr++;
    end
  endfunction

  function automatic logic [STAT_W-1:0] close_frame();
    ld_phase = AWAIT_HI;
    return ld_overflow ? ST_OVERFLOW : ST_DONE;
  endfunction

  function automatic line_result_t predict_line_result(logic [MODE_W-1:0] mode,
                                                       logic [DATA_W-1:0] data,
                                                       logic [RIDX_W-1:0] ridx);
    line_result_t r;
    r.status    = ST_PENDING;
    r.read_data = '0;
    if (mode == MODE_READ) begin
      r.read_data = line_copy[ridx];
    end else if (mode == MODE_RAW || mode == MODE_COMP) begin
      case (ld_phase)
        AWAIT_HI: begin
          ld_frame_len = {data, 8'h00};
          ld_phase     = AWAIT_LO;
        end
        AWAIT_LO: begin
          // The mode of the low length byte decides the frame kind
          ld_frame_len[7:0] = data;
          ld_byte_cnt = 0;
          ld_bit_ptr  = 0;
          ld_overflow = 1'b0;
          ld_token_hi = '0;
          if (mode == MODE_RAW && ld_frame_len != line_bytes_cfg) begin
            r.status = ST_MISMATCH;
            ld_phase = AWAIT_HI;
          end else if (ld_frame_len == 0) begin
            r.status = close_frame();
          end else begin
            ld_phase = (mode == MODE_RAW) ? RAW_BYTES : RUN_TOKENS;
          end
        end
        RAW_BYTES: begin
          if (ld_byte_cnt < BUF_BYTES) begin
            line_copy[ld_byte_cnt] = data;
            note_known(ld_byte_cnt, 8'hFF);
            ld_bit_ptr = (ld_byte_cnt + 1) * 8;
          end else begin
            ld_overflow = 1'b1;
          end
          ld_byte_cnt++;
          if (ld_byte_cnt >= ld_frame_len) r.status = close_frame();
        end
        default: begin
          // Tokens complete on even byte counts, so an odd length takes one extra byte
          ld_byte_cnt++;
          if (ld_byte_cnt % 2 == 1) begin
            ld_token_hi = data;
          end else begin
            lay_run((ld_token_hi & TOKEN_ONES_BIT) != 0, {ld_token_hi & TOKEN_LEN_MASK, data});
            if (ld_byte_cnt >= ld_frame_len) r.status = close_frame();
          end
        end
      endcase
    end
    r.fill_bits = FILL_W'((ld_bit_ptr > CAP_BITS) ? CAP_BITS : ld_bit_ptr);
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= 25)
      $display("mismatch at cycle %0d, result %0d: %s got 0x%0h, expected 0x%0h",
               cycle_count, results_seen, what, got, want);
  endtask

  task automatic check_result(logic [31:0] beat);
    line_result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch("result beat with nothing pending", beat, 0);
      return;
    end
    want = pending_results.pop_front();
    if (beat[1:0] != want.status)    report_mismatch("status", beat[1:0], want.status);
    if (beat[9:2] != want.read_data) report_mismatch("read_data", beat[9:2], want.read_data);
    if (beat[25:10] != want.fill_bits)
      report_mismatch("fill_bits", beat[25:10], want.fill_bits);
  endtask

  // Sample the result handshake on pre-edge values, then pick the next tready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(m_tdata);
    m_tready <= (hold_left == 0) && (no_idle || $urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("tb_run_length_line_buffer_loader: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  // Offer one beat, hold it until accepted, then predict its result
  task automatic send_beat(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] data,
                           logic [RIDX_W-1:0] ridx);
    line_result_t want;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {4'b0, ridx, data};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = predict_line_result(mode, data, ridx);
    pending_results.push_back(want);
    if (mode != MODE_IGNORED) beats_sent++;
    if (mode == MODE_READ) reads_done++;
    case (want.status)
      ST_DONE:     frames_ok++;
      ST_MISMATCH: frames_refused++;
      ST_OVERFLOW: frames_clipped++;
      default: ;
    endcase
  endtask

  task automatic send_byte(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] data);
    send_beat(mode, data, RIDX_W'($urandom_range(4095)));
  endtask

  task automatic read_byte(int idx);
    send_beat(MODE_READ, DATA_W'($urandom_range(255)), RIDX_W'(idx));
  endtask

  function automatic logic [MODE_W-1:0] rand_stream_mode();
    return $urandom_range(1) ? MODE_COMP : MODE_RAW;
  endfunction

  // High length byte carries either stream mode; the low byte's mode sets the frame kind
  task automatic send_header(logic [MODE_W-1:0] kind, logic [LEN_W-1:0] len);
    send_byte(rand_stream_mode(), len[15:8]);
    send_byte(kind, len[7:0]);
  endtask

  task automatic send_token(logic ones, logic [RUN_W-1:0] run, logic [MODE_W-1:0] mode);
    send_byte(mode, {ones, run[14:8]});
    send_byte(mode, run[7:0]);
  endtask

  // Pause the sender until every expected result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_line_bytes(logic [CFG_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    line_bytes_cfg = value;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Empty frames, length refusals, a short raw line with mixed payload modes, mode 3
  task automatic test_raw_frames();
    set_line_bytes(0);
    send_byte(MODE_RAW, 8'h00);
    send_beat(MODE_IGNORED, 8'hFF, 12'hFFF);   // ignored between the length bytes
    send_byte(MODE_RAW, 8'h00);
    send_header(MODE_RAW, 16'h0005);
    send_header(MODE_COMP, 16'h0000);
    set_line_bytes(4095);
    send_header(MODE_RAW, 16'h0FFE);
    send_header(MODE_RAW, 16'hFFFF);
    set_line_bytes(3);
    send_header(MODE_RAW, 16'h0003);
    send_byte(MODE_RAW, 8'h00);
    send_byte(MODE_COMP, 8'hFF);               // payload byte's mode is not checked
    send_byte(MODE_RAW, 8'hA5);
    for (int i = 0; i < 3; i++) read_byte(i);
  endtask

  // Runs of ones and zeros, a zero-length run, an odd frame length
  task automatic test_runs();
    send_header(MODE_COMP, 16'd7);
    send_token(1'b1, 15'd13, MODE_COMP);
    send_token(1'b0, 15'd3, MODE_RAW);
    send_token(1'b1, 15'd0, MODE_COMP);
    send_token(1'b1, 15'd4, MODE_COMP);        // first byte completes the length, second ends it
    for (int i = 0; i < 3; i++) read_byte(i);
  endtask

  // A raw line streamed back to back, with neither side idling
  task automatic test_steady_stream();
    set_line_bytes(CFG_W'(STREAM_BYTES));
    no_idle <= 1'b1;
    send_header(MODE_RAW, LEN_W'(STREAM_BYTES));
    for (int i = 0; i < STREAM_BYTES; i++)
      send_byte(rand_stream_mode(), DATA_W'($urandom_range(255)));
    read_byte(0);
    read_byte(STREAM_BYTES - 1);
    no_idle <= 1'b0;
  endtask

  // Fill the line exactly, then overrun it
  task automatic test_capacity();
    send_header(MODE_COMP, 16'd4);
    send_token(1'b1, 15'h7FFF, MODE_COMP);
    send_token(1'b0, 15'd1, MODE_COMP);
    read_byte(BUF_BYTES - 1);
    send_header(MODE_COMP, 16'd4);
    send_token(1'b0, 15'h7FFF, MODE_COMP);
    send_token(1'b1, 15'h7FFF, MODE_COMP);
    read_byte(BUF_BYTES - 2);
    read_byte(BUF_BYTES - 1);
  endtask

  // Hold the receiver off while beats keep coming, so the queue fills and tready drops
  task automatic test_backpressure();
    wait_drained();
    hold_go <= ~hold_go;
    send_header(MODE_COMP, 16'd6);
    for (int i = 0; i < 3; i++)
      send_token(1'($urandom_range(1)), RUN_W'($urandom_range(40)), MODE_COMP);
    for (int i = 0; i < 6; i++) read_byte(readable[$urandom_range(readable.size() - 1)]);
    wait_drained();
  endtask

  function automatic logic [RUN_W-1:0] pick_run_len();
    int r;
    r = $urandom_range(99);
    if (r < 85) return RUN_W'($urandom_range(40));
    if (r < 97) return RUN_W'($urandom_range(2000));
    return RUN_W'($urandom_range(32767));
  endfunction

  // Sprinkle reads and ignored beats into frames
  task automatic maybe_interleave();
    int r;
    r = $urandom_range(99);
    if (r < 10 && readable.size() != 0)
      read_byte(readable[$urandom_range(readable.size() - 1)]);
    else if (r < 14)
      send_beat(MODE_IGNORED, DATA_W'($urandom_range(255)), RIDX_W'($urandom_range(4095)));
  endtask

  task automatic send_random_frame();
    int               pick;
    int               ntok;
    logic [LEN_W-1:0] len;
    pick = $urandom_range(99);
    if (pick < 40) begin
      // Raw: mostly the configured length while it is short, else a refused length
      if (line_bytes_cfg <= 32 && $urandom_range(9) < 8) begin
        len = LEN_W'(line_bytes_cfg);
      end else begin
        do len = LEN_W'($urandom_range(16'hFFFF)); while (len == line_bytes_cfg);
      end
      send_header(MODE_RAW, len);
      if (len == line_bytes_cfg) begin
        for (int i = 0; i < len; i++) begin
          maybe_interleave();
          send_byte(rand_stream_mode(), DATA_W'($urandom_range(255)));
        end
      end
    end else if (pick < 85) begin
      ntok = $urandom_range(4);
      len  = LEN_W'(2 * ntok);
      if (ntok != 0 && $urandom_range(3) == 0) len = len - LEN_W'(1);
      send_header(MODE_COMP, len);
      for (int i = 0; i < ntok; i++) begin
        maybe_interleave();
        send_token(1'($urandom_range(1)), pick_run_len(), rand_stream_mode());
      end
    end else begin
      // Noise: reads and ignored beats between frames
      maybe_interleave();
      send_beat(MODE_IGNORED, DATA_W'($urandom_range(255)), RIDX_W'($urandom_range(4095)));
      if (readable.size() != 0) read_byte(readable[$urandom_range(readable.size() - 1)]);
    end
  endtask

  // Random frames under four line lengths; long lengths only ever see refused raw frames
  task automatic test_random_traffic();
    int start;
    for (int s = 0; s < 4; s++) begin
      case (s)
        0:       set_line_bytes(0);
        1:       set_line_bytes(CFG_W'($urandom_range(1, 8)));
        2:       set_line_bytes(CFG_W'($urandom_range(9, 32)));
        default: set_line_bytes(CFG_W'($urandom_range(33, 4096)));
      endcase
      start = beats_sent;
      while (beats_sent - start < RANDOM_BEATS / 4) send_random_frame();
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_raw_frames();
    test_runs();
    test_steady_stream();
    test_capacity();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (16) @(posedge clk);
    $display("covered %0d beats and %0d results over %0d line length settings, all four modes",
             beats_sent, results_seen, settings_used);
    $display("frames: %0d accepted, %0d refused on length, %0d overran the line; %0d reads",
             frames_ok, frames_refused, frames_clipped, reads_done);
    if (mismatch_count == 0) begin
      $display("tb_run_length_line_buffer_loader: PASS");
    end else begin
      $display("tb_run_length_line_buffer_loader: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/rlb_pkg.sv
rtl/rlb_front.sv
rtl/rlb_queue.sv
rtl/rlb_back.sv
rtl/run_length_line_buffer_loader.sv
tb/tb_run_length_line_buffer_loader.sv
